// File: src/dptq_pkg.sv
// ----------------------------------------------------------------------------
// dptq_pkg - shared types and constants of the dual priority task queue
// Item layouts, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package dptq_pkg;

	localparam int DEF_FIFO_DEPTH  = 16;
	localparam int DEF_HANDLE_BITS = 16;

	localparam int HANDLE_W = 16;
	localparam int OCC_W    = 6;
	localparam int CFG_W    = 6;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_PUT_OK    = 2'd0,
		ST_PUT_FULL  = 2'd1,
		ST_DELIVERED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic                kind;
		logic                high_priority;
		logic [HANDLE_W-1:0] task_handle;
	} req_item_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] task_out;
		logic                from_high;
		logic                last;
		logic [OCC_W-1:0]    occupancy;
	} rsp_item_t;

endpackage

// File: src/dptq_ram.sv
// ----------------------------------------------------------------------------
// dptq_ram - simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dptq_ram #(
	parameter int DEPTH = dptq_pkg::DEF_FIFO_DEPTH,
	parameter int WIDTH = dptq_pkg::DEF_HANDLE_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/dptq_ctrl.sv
// ----------------------------------------------------------------------------
// dptq_ctrl - queue controller
// Holds heads, counts and the limit register, runs puts and takes against
// the two FIFO memories and owns the result register.
// ----------------------------------------------------------------------------
module dptq_ctrl #(
	parameter int FIFO_DEPTH  = dptq_pkg::DEF_FIFO_DEPTH,
	parameter int HANDLE_BITS = dptq_pkg::DEF_HANDLE_BITS,
	localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  dptq_pkg::req_item_t       req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output dptq_pkg::rsp_item_t       rsp,
	input  logic                      cfg_wen,
	input  logic [dptq_pkg::CFG_W-1:0] cfg_wdata,
	output logic                      hi_we,
	output logic [PTR_W-1:0]          hi_waddr,
	output logic [PTR_W-1:0]          hi_raddr,
	output logic [HANDLE_BITS-1:0]    hi_wdata,
	input  logic [HANDLE_BITS-1:0]    hi_rdata,
	output logic                      nm_we,
	output logic [PTR_W-1:0]          nm_waddr,
	output logic [PTR_W-1:0]          nm_raddr,
	output logic [HANDLE_BITS-1:0]    nm_wdata,
	input  logic [HANDLE_BITS-1:0]    nm_rdata
);

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int TOT_W = CNT_W + 1;
	localparam int CMP_W = (TOT_W > dptq_pkg::CFG_W) ? TOT_W : dptq_pkg::CFG_W;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	dptq_pkg::state_t    state_q, state_d;
	dptq_pkg::req_item_t item_q;
	dptq_pkg::rsp_item_t rsp_q, res;
	logic                rsp_valid_q;
	logic [dptq_pkg::CFG_W-1:0] max_q;

	logic [PTR_W-1:0] hh_q, hh_d, nh_q, nh_d;
	logic [CNT_W-1:0] hc_q, hc_d, nc_q, nc_d;

	logic             out_free, exec, load, req_acc, is_put, full, drain_more;
	logic [TOT_W-1:0] total;
	logic [CNT_W-1:0] sel_cnt;
	logic [PTR_W-1:0] sel_head, tail;
	logic [SUM_W-1:0] tail_sum;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign exec     = (state_q == dptq_pkg::S_EXEC) && out_free;
	assign req_acc  = req_valid && !req_stall;
	assign req_stall = (state_q != dptq_pkg::S_IDLE);

	assign is_put   = (item_q.kind == dptq_pkg::KIND_PUT);
	assign total    = TOT_W'(hc_q) + TOT_W'(nc_q);
	assign sel_cnt  = item_q.high_priority ? hc_q : nc_q;
	assign sel_head = item_q.high_priority ? hh_q : nh_q;
	assign tail_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
	assign tail     = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
	                  PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
	assign full     = ((max_q != '0) && (CMP_W'(total) >= CMP_W'(max_q))) ||
	                  (sel_cnt == CNT_W'(FIFO_DEPTH));
	assign drain_more = !is_put && (hc_q > CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dptq_pkg::S_IDLE: begin
				if (req_acc) begin
					state_d = dptq_pkg::S_EXEC;
				end
			end
			dptq_pkg::S_EXEC: begin
				if (exec && !drain_more) begin
					state_d = dptq_pkg::S_IDLE;
				end
			end
			default: state_d = dptq_pkg::S_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		res       = '0;
		res.last  = 1'b1;
		res.occupancy = dptq_pkg::OCC_W'(total);
		load      = 1'b0;
		hh_d      = hh_q;
		nh_d      = nh_q;
		hc_d      = hc_q;
		nc_d      = nc_q;
		hi_we     = 1'b0;
		nm_we     = 1'b0;
		if (exec) begin
			load = 1'b1;
			priority if (is_put) begin
				if (full) begin
					res.status = dptq_pkg::ST_PUT_FULL;
				end else begin
					res.status    = dptq_pkg::ST_PUT_OK;
					res.occupancy = dptq_pkg::OCC_W'(total + TOT_W'(1));
					if (item_q.high_priority) begin
						hi_we = 1'b1;
						hc_d  = hc_q + CNT_W'(1);
					end else begin
						nm_we = 1'b1;
						nc_d  = nc_q + CNT_W'(1);
					end
				end
			end else if (hc_q != '0) begin
				res.status    = dptq_pkg::ST_DELIVERED;
				res.task_out  = dptq_pkg::HANDLE_W'(hi_rdata);
				res.from_high = 1'b1;
				res.last      = (hc_q == CNT_W'(1));
				res.occupancy = dptq_pkg::OCC_W'(total - TOT_W'(1));
				hh_d = ptr_inc(hh_q);
				hc_d = hc_q - CNT_W'(1);
			end else if (nc_q != '0) begin
				res.status    = dptq_pkg::ST_DELIVERED;
				res.task_out  = dptq_pkg::HANDLE_W'(nm_rdata);
				res.occupancy = dptq_pkg::OCC_W'(total - TOT_W'(1));
				nh_d = ptr_inc(nh_q);
				nc_d = nc_q - CNT_W'(1);
			end else begin
				res.status = dptq_pkg::ST_EMPTY;
			end
		end
	end

	// Read ports follow the next head, so the head entry is always ready in the
	// next cycle; a drain gives one item per cycle unless the result stalls. A
	// put always returns to idle first, so its write lands before a take reads it.
	assign hi_raddr = hh_d;
	assign nm_raddr = nh_d;
	assign hi_waddr = tail;
	assign nm_waddr = tail;
	assign hi_wdata = HANDLE_BITS'(item_q.task_handle);
	assign nm_wdata = HANDLE_BITS'(item_q.task_handle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dptq_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			max_q       <= '0;
			hh_q        <= '0;
			nh_q        <= '0;
			hc_q        <= '0;
			nc_q        <= '0;
		end else begin
			state_q <= state_d;
			hh_q    <= hh_d;
			nh_q    <= nh_d;
			hc_q    <= hc_d;
			nc_q    <= nc_d;
			if (cfg_wen) begin
				max_q <= cfg_wdata;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req;
		end
		if (load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/dual_priority_task_queue.sv
// ----------------------------------------------------------------------------
// dual_priority_task_queue - two level priority FIFO queue of task handles
// High and normal FIFOs in two RAMs under one shared occupancy limit.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | carries
//  --------+--------------------------+-----------+---------------------------
//  req     | req_valid, req_stall,req | in        | put or take command item
//  rsp     | rsp_valid, rsp_stall,rsp | out       | result item(s) per command
//  cfg     | cfg_wen, cfg_wdata       | in        | max_queue_size register
//
//  A put or a take of one item is accepted, then executed against the RAM.
//  A high drain of n entries gives one result per cycle while the result is
//  not stalled; the registered RAM read of the next head sets the step.
//  Reset clears heads, counts, the limit and the result valid flag; the RAM
//  contents are not cleared. A stalled result holds the exec state in place.
// ----------------------------------------------------------------------------
module dual_priority_task_queue #(
	parameter int FIFO_DEPTH  = dptq_pkg::DEF_FIFO_DEPTH,
	parameter int HANDLE_BITS = dptq_pkg::DEF_HANDLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  dptq_pkg::req_item_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output dptq_pkg::rsp_item_t        rsp,
	input  logic                       cfg_wen,
	input  logic [dptq_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic                   hi_we, nm_we;
	logic [PTR_W-1:0]       hi_waddr, hi_raddr, nm_waddr, nm_raddr;
	logic [HANDLE_BITS-1:0] hi_wdata, hi_rdata, nm_wdata, nm_rdata;

	dptq_ctrl #(
		.FIFO_DEPTH  (FIFO_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.hi_we     (hi_we),
		.hi_waddr  (hi_waddr),
		.hi_raddr  (hi_raddr),
		.hi_wdata  (hi_wdata),
		.hi_rdata  (hi_rdata),
		.nm_we     (nm_we),
		.nm_waddr  (nm_waddr),
		.nm_raddr  (nm_raddr),
		.nm_wdata  (nm_wdata),
		.nm_rdata  (nm_rdata)
	);

	dptq_ram #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (HANDLE_BITS)
	) u_high_ram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (hi_waddr),
		.wdata (hi_wdata),
		.raddr (hi_raddr),
		.rdata (hi_rdata)
	);

	dptq_ram #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH (HANDLE_BITS)
	) u_normal_ram (
		.clk   (clk),
		.we    (nm_we),
		.waddr (nm_waddr),
		.wdata (nm_wdata),
		.raddr (nm_raddr),
		.rdata (nm_rdata)
	);

	// an accepted command keeps the input closed while it executes
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input open right after accepting an item");

	// only a delivery carries a handle or a high flag
	a_no_stray_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != dptq_pkg::ST_DELIVERED |->
		rsp.task_out == '0 && !rsp.from_high)
		else $error("handle on a result that delivers nothing");

	// puts, empty takes and normal takes end their command at once
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.from_high |-> rsp.last)
		else $error("single result without last");

endmodule
